### hw/rtl/vt4_pkg.sv
package vt4_pkg;

   localparam int unsigned NumRows     = 4;
   localparam int unsigned NumCols     = 4;
   localparam int unsigned CoefWidth   = 16;
   localparam int unsigned CompWidth   = 16;
   localparam int unsigned ColWidth    = NumRows * CoefWidth;
   localparam int unsigned ProdWidth   = CoefWidth + CompWidth;
   localparam int unsigned PairWidth   = ProdWidth + 1;
   localparam int unsigned TotalWidth  = PairWidth + 1;
   localparam int unsigned FracShift   = 12;
   localparam int unsigned ResWidth    = 24;
   localparam int unsigned ReqWidth    = NumCols * CompWidth;
   localparam int unsigned RspWidth    = NumRows * ResWidth;
   localparam int unsigned CsrAddrWidth = 3;

   typedef logic [CsrAddrWidth-1:0] csr_addr_type;

   localparam csr_addr_type CSR_COLUMN_0    = 3'd0;
   localparam csr_addr_type CSR_COLUMN_1    = 3'd1;
   localparam csr_addr_type CSR_COLUMN_2    = 3'd2;
   localparam csr_addr_type CSR_COLUMN_3    = 3'd3;
   localparam csr_addr_type CSR_AFFINE_MODE = 3'd4;

   localparam logic [ColWidth-1:0] COLUMN_0_RESET = 64'h0000_0000_0000_1000;
   localparam logic [ColWidth-1:0] COLUMN_1_RESET = 64'h0000_0000_1000_0000;
   localparam logic [ColWidth-1:0] COLUMN_2_RESET = 64'h0000_1000_0000_0000;
   localparam logic [ColWidth-1:0] COLUMN_3_RESET = 64'h1000_0000_0000_0000;

   // translation scaled so that coef * operand lands in the product format
   localparam logic signed [CompWidth-1:0] TRANSLATE_OPERAND = 16'sd256;

   typedef struct packed {
      logic [NumCols-1:0][ColWidth-1:0] columns;
      logic                             affine;
   } cfg_type;

   typedef logic [NumCols-1:0][CompWidth-1:0]            vec_type;
   typedef logic [NumRows-1:0][NumCols-1:0][ProdWidth-1:0] prod_type;
   typedef logic [NumRows-1:0][1:0][PairWidth-1:0]       pair_type;
   typedef logic [NumRows-1:0][ResWidth-1:0]             res_type;

endpackage

### hw/rtl/vt4_csr.sv
module vt4_csr
   import vt4_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  csr_addr_type        csr_addr,
   input  logic [ColWidth-1:0] csr_wdata,
   output cfg_type             cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_COLUMN_0:    cfg_in.columns[0] = csr_wdata;
            CSR_COLUMN_1:    cfg_in.columns[1] = csr_wdata;
            CSR_COLUMN_2:    cfg_in.columns[2] = csr_wdata;
            CSR_COLUMN_3:    cfg_in.columns[3] = csr_wdata;
            CSR_AFFINE_MODE: cfg_in.affine     = csr_wdata[0];
            default:         cfg_in            = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.columns[0] <= COLUMN_0_RESET;
         cfg_ff.columns[1] <= COLUMN_1_RESET;
         cfg_ff.columns[2] <= COLUMN_2_RESET;
         cfg_ff.columns[3] <= COLUMN_3_RESET;
         cfg_ff.affine     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/vt4_mul.sv
module vt4_mul
   import vt4_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_valid,
   output logic     in_ready,
   input  vec_type  in_vec,
   input  logic     in_last,
   output logic     out_valid,
   input  logic     out_ready,
   output prod_type out_prod,
   output logic     out_last
);

   logic                        valid_ff;
   logic                        valid_in;
   prod_type                    prod_ff;
   prod_type                    prod_in;
   logic                        last_ff;
   logic signed [CompWidth-1:0] opnd [NumCols];

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      for (int c = 0; c < NumCols; c++) begin
         opnd[c] = $signed(in_vec[c]);
      end
      // affine mode adds the fourth column as a translation
      if (cfg.affine) begin
         opnd[NumCols-1] = TRANSLATE_OPERAND;
      end
      for (int r = 0; r < NumRows; r++) begin
         for (int c = 0; c < NumCols; c++) begin
            prod_in[r][c] = ProdWidth'($signed(cfg.columns[c][CoefWidth*r +: CoefWidth])) *
                            ProdWidth'(opnd[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         prod_ff <= prod_in;
         last_ff <= in_last;
      end
   end

   assign out_valid = valid_ff;
   assign out_prod  = prod_ff;
   assign out_last  = last_ff;

endmodule

### hw/rtl/vt4_add.sv
module vt4_add
   import vt4_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  prod_type in_prod,
   input  logic     in_last,
   output logic     out_valid,
   input  logic     out_ready,
   output pair_type out_pair,
   output logic     out_last
);

   logic     valid_ff;
   logic     valid_in;
   pair_type pair_ff;
   pair_type pair_in;
   logic     last_ff;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      for (int r = 0; r < NumRows; r++) begin
         pair_in[r][0] = PairWidth'($signed(in_prod[r][0])) + PairWidth'($signed(in_prod[r][1]));
         pair_in[r][1] = PairWidth'($signed(in_prod[r][2])) + PairWidth'($signed(in_prod[r][3]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         pair_ff <= pair_in;
         last_ff <= in_last;
      end
   end

   assign out_valid = valid_ff;
   assign out_pair  = pair_ff;
   assign out_last  = last_ff;

endmodule

### hw/rtl/vt4_sum.sv
module vt4_sum
   import vt4_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  pair_type in_pair,
   input  logic     in_last,
   output logic     out_valid,
   input  logic     out_ready,
   output res_type  out_res,
   output logic     out_last
);

   logic                         valid_ff;
   logic                         valid_in;
   res_type                      res_ff;
   res_type                      res_in;
   logic                         last_ff;
   logic signed [TotalWidth-1:0] total [NumRows];

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      for (int r = 0; r < NumRows; r++) begin
         total[r]  = TotalWidth'($signed(in_pair[r][0])) + TotalWidth'($signed(in_pair[r][1]));
         // floor shift, sign extended to the result width
         res_in[r] = ResWidth'(total[r] >>> FracShift);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         res_ff  <= res_in;
         last_ff <= in_last;
      end
   end

   assign out_valid = valid_ff;
   assign out_res   = res_ff;
   assign out_last  = last_ff;

endmodule

### hw/rtl/vertex_transform_4x4_core.sv
// Fixed-point 4x4 matrix-vector transform. Each item is one vector (x, y, z, w), signed
// Q7.8, multiplied by a column-major matrix of signed Q3.12 coefficients written through
// the csr port; in affine mode the fourth column is added as a translation and w is not
// used. Each result is the exact sum shifted right by 12 (floor), signed Q.8 in 24 bits,
// with the last flag copied through. The pipeline takes one item per clock unless rsp_tready
// stalls it, and has three register stages: sixteen parallel 16x16 multipliers, a pairwise
// add, and the final add with shift, whose register is also the output register. Stalls on
// rsp_tready back up through the stages without loss.
// Matrix and mode must be written only while no items are in flight.
module vertex_transform_4x4_core
   import vt4_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqWidth-1:0] req_tdata,  // in_x, in_y, in_z, in_w
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspWidth-1:0] rsp_tdata,  // out_x, out_y, out_z, out_w
   output logic                rsp_tlast,
   input  logic                csr_we,
   input  csr_addr_type        csr_addr,
   input  logic [ColWidth-1:0] csr_wdata
);

   cfg_type  cfg;
   logic     mul_valid;
   logic     mul_ready;
   prod_type mul_prod;
   logic     mul_last;
   logic     add_valid;
   logic     add_ready;
   pair_type add_pair;
   logic     add_last;
   res_type  sum_res;

   vt4_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   vt4_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_vec    (vec_type'(req_tdata)),
      .in_last   (req_tlast),
      .out_valid (mul_valid),
      .out_ready (mul_ready),
      .out_prod  (mul_prod),
      .out_last  (mul_last)
   );

   vt4_add u_add (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .in_ready  (mul_ready),
      .in_prod   (mul_prod),
      .in_last   (mul_last),
      .out_valid (add_valid),
      .out_ready (add_ready),
      .out_pair  (add_pair),
      .out_last  (add_last)
   );

   vt4_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (add_valid),
      .in_ready  (add_ready),
      .in_pair   (add_pair),
      .in_last   (add_last),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (sum_res),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = RspWidth'(sum_res);

endmodule

### hw/rtl/vt4_checker.sv
module vt4_checker
   import vt4_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RspWidth-1:0] rsp_tdata,
   input logic                rsp_tlast
);

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp item changed while stalled");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   // an empty output stage means the pipeline can take an item
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty output stage");

   // an accepted item reaches the output when rsp_tready stays high behind it
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("accepted item did not reach the output");

endmodule

bind vertex_transform_4x4_core vt4_checker u_vt4_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
